>>> hdl/pcms_pkg.sv
// ----------------------------------------------------------------------------
// pcms_pkg: shared types and helpers for the pixel colour map scaler
// Holds the configuration record, the fixed widths and the logarithm helpers.
// ----------------------------------------------------------------------------
package pcms_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned LogFrac  = 16;
  localparam int unsigned DivBits  = 8;   // quotient bits below the saturation check
  localparam int unsigned DvdW     = 41;  // 9-bit count times 32-bit operand
  localparam int unsigned DvsW     = 31;

  localparam logic [1:0] RegNumColors = 2'd0;
  localparam logic [1:0] RegZeroLevel = 2'd1;
  localparam logic [1:0] RegRange     = 2'd2;
  localparam logic [1:0] RegLogMode   = 2'd3;

  typedef struct packed {
    logic [8:0]         num_colors;
    logic signed [31:0] zero_level;
    logic [30:0]        display_range;
    logic               log_mode;
  } pcms_cfg_t;

  // Position of the most significant set bit; zero for an all-zero word.
  function automatic logic [4:0] lead_one(input logic [31:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  // Mitchell log2 of a value of at least 1.0 whose leading one sits at p.
  function automatic logic [31:0] mitchell(input logic [31:0] x, input logic [4:0] p);
    logic [31:0] rest;
    logic [4:0]  sh;
    logic [31:0] frac;
    rest = x & ~(32'd1 << p);
    sh   = p - 5'(FracBits);
    frac = rest >> sh;
    return ({27'd0, sh} << LogFrac) + {16'd0, frac[LogFrac-1:0]};
  endfunction

endpackage

>>> hdl/pcms_prep.sv
// ----------------------------------------------------------------------------
// pcms_prep: operand preparation pipeline
// Forms the offset, the Mitchell logarithms and the scaled dividend.
// ----------------------------------------------------------------------------
module pcms_prep import pcms_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [31:0]       pixel_i,
  input  pcms_cfg_t         cfg_i,
  output logic              valid_o,
  output logic [DvdW-1:0]   dividend_o,
  output logic [DvsW-1:0]   divisor_o,
  output logic [7:0]        cap_o
);

  localparam logic [31:0] One = 32'd1 << FracBits;
  localparam logic [30:0] Two = 31'd2 << FracBits;

  logic [3:0]         valid_q;
  logic signed [32:0] diff_q;
  logic [31:0]        x_q, a_q;
  logic [30:0]        r_q, d_q;
  logic [4:0]         px_q, pr_q;
  logic [31:0]        x_d;
  logic [30:0]        r_d;
  logic [31:0]        lx, lr;
  logic [DvdW-1:0]    dividend_q;
  logic [DvsW-1:0]    divisor_q;
  logic [7:0]         cap_q, cap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_comb begin
    if (cfg_i.log_mode) begin
      x_d = (diff_q > $signed({1'b0, One})) ? diff_q[31:0] : One;
      r_d = (cfg_i.display_range < Two) ? Two : cfg_i.display_range;
    end else begin
      x_d = (diff_q > 33'sd0) ? diff_q[31:0] : 32'd0;
      r_d = (cfg_i.display_range == '0) ? 31'd1 : cfg_i.display_range;
    end
    lx = mitchell(x_q, px_q);
    lr = mitchell({1'b0, r_q}, pr_q);
    if (lr == '0) lr = 32'd1;
    if (cfg_i.num_colors <= 9'd1) cap_d = 8'd0;
    else if (cfg_i.num_colors > 9'd256) cap_d = 8'd255;
    else cap_d = 8'(cfg_i.num_colors - 9'd1);
  end

  always_ff @(posedge clk_i) begin
    diff_q <= $signed({pixel_i[31], pixel_i}) - $signed({cfg_i.zero_level[31], cfg_i.zero_level});
    x_q    <= x_d;
    r_q    <= r_d;
    px_q   <= lead_one(x_d);
    pr_q   <= lead_one({1'b0, r_d});
    a_q    <= cfg_i.log_mode ? lx : x_q;
    d_q    <= cfg_i.log_mode ? lr[30:0] : r_q;
    dividend_q <= DvdW'({32'd0, cfg_i.num_colors} * {9'd0, a_q});
    divisor_q  <= d_q;
    cap_q      <= cap_d;
  end

  assign valid_o    = valid_q[3];
  assign dividend_o = dividend_q;
  assign divisor_o  = divisor_q;
  assign cap_o      = cap_q;

endmodule

>>> hdl/pcms_div.sv
// ----------------------------------------------------------------------------
// pcms_div: pipelined saturating divider
// A saturation check followed by one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module pcms_div import pcms_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  input  logic [7:0]      cap_i,
  output logic            valid_o,
  output logic [7:0]      quot_o,
  output logic [7:0]      cap_o
);

  logic [DivBits:0] valid_q;
  logic [DvdW-1:0]  rem_q  [0:DivBits];
  logic [DvsW-1:0]  dvs_q  [0:DivBits];
  logic [7:0]       quot_q [0:DivBits];
  logic [7:0]       cap_q  [0:DivBits];
  logic             sat_q  [0:DivBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[DivBits-1:0], valid_i};
    end
  end

  // The quotient is only needed up to 255: anything larger saturates here.
  always_ff @(posedge clk_i) begin
    sat_q[0]  <= dividend_i >= (DvdW'(divisor_i) << DivBits);
    rem_q[0]  <= dividend_i;
    dvs_q[0]  <= divisor_i;
    quot_q[0] <= '0;
    cap_q[0]  <= cap_i;
  end

  for (genvar s = 1; s <= DivBits; s++) begin : g_stage
    localparam int unsigned K = DivBits - s;
    logic [DvdW-1:0] sub;
    logic            take;
    assign sub  = DvdW'(dvs_q[s-1]) << K;
    assign take = rem_q[s-1] >= sub;
    always_ff @(posedge clk_i) begin
      rem_q[s]  <= take ? rem_q[s-1] - sub : rem_q[s-1];
      quot_q[s] <= quot_q[s-1] | (take ? (8'd1 << K) : 8'd0);
      dvs_q[s]  <= dvs_q[s-1];
      cap_q[s]  <= cap_q[s-1];
      sat_q[s]  <= sat_q[s-1];
    end
  end

  assign valid_o = valid_q[DivBits];
  assign quot_o  = sat_q[DivBits] ? 8'd255 : quot_q[DivBits];
  assign cap_o   = cap_q[DivBits];

endmodule

>>> hdl/pixel_colormap_scaler.sv
// ----------------------------------------------------------------------------
// pixel_colormap_scaler: linear or logarithmic pixel to colour index stretch
// Fully pipelined: one request per clock, busy_o never rises.
// ----------------------------------------------------------------------------
// done_o strobes when the request leaves the prep, divider and output registers.
// Throughput: one request every cycle, set by the one-bit-per-stage divider.
// The receiver cannot stall, so results leave on fixed timing.
// Reset (rst_ni low, asynchronous) empties the pipeline and restores the
// registers to 256 colours, zero level 0, range 256.0 and linear mode.
module pixel_colormap_scaler import pcms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] pixel_i,
  output logic        done_o,
  output logic [7:0]  color_index_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  pcms_cfg_t       cfg_q;
  logic            prep_valid, div_valid;
  logic [DvdW-1:0] dividend;
  logic [DvsW-1:0] divisor;
  logic [7:0]      prep_cap, div_cap, quot;
  logic            done_q;
  logic [7:0]      index_q;

  // Configuration registers. Writes must only be made while the pipeline is
  // empty; the block itself does not enforce this. Every stage reads them directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_colors    <= 9'd256;
      cfg_q.zero_level    <= '0;
      cfg_q.display_range <= 31'd16777216;
      cfg_q.log_mode      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegNumColors: cfg_q.num_colors    <= cfg_wdata_i[8:0];
        RegZeroLevel: cfg_q.zero_level    <= cfg_wdata_i;
        RegRange:     cfg_q.display_range <= cfg_wdata_i[30:0];
        RegLogMode:   cfg_q.log_mode      <= cfg_wdata_i[0];
        default:      ;
      endcase
    end
  end

  // The pipeline never holds a request back.
  assign busy_o = 1'b0;

  pcms_prep u_prep (
    .clk_i,
    .rst_ni,
    .valid_i    (start_i),
    .pixel_i,
    .cfg_i      (cfg_q),
    .valid_o    (prep_valid),
    .dividend_o (dividend),
    .divisor_o  (divisor),
    .cap_o      (prep_cap)
  );

  pcms_div u_div (
    .clk_i,
    .rst_ni,
    .valid_i    (prep_valid),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .cap_i      (prep_cap),
    .valid_o    (div_valid),
    .quot_o     (quot),
    .cap_o      (div_cap)
  );

  // Final clamp to the last usable colour, registered onto the ports.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    index_q <= (quot > div_cap) ? div_cap : quot;
  end

  assign done_o        = done_q;
  assign color_index_o = index_q;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the pixel colour map scaler
// Drives pixels through the command handshake under several register settings,
// predicts each colour index with an independent linear and Mitchell-log model
// and compares every strobed result in order against the predicted indices.
// ----------------------------------------------------------------------------
module tb;
  import pcms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Latency   = 14;
  localparam longint      CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] pixel_i = '0;
  logic        done_o;
  logic [7:0]  color_index_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = RegNumColors;
  logic [31:0] cfg_wdata_i = '0;

  // The bench keeps its own copy of the registers for prediction.
  logic [8:0]         cur_colors;
  logic signed [31:0] cur_zero;
  logic [30:0]        cur_range;
  logic               cur_log;

  logic [7:0] index_queue[$];
  int         mismatches = 0;
  longint     cycles = 0;

  pixel_colormap_scaler u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Watchdog: any hang in the handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mitchell log2 of a Q16.16 value of at least 1.0; integer part is the
  // leading-one position less the fraction width, fraction is the mantissa.
  function automatic longint unsigned approx_log2(input longint unsigned x);
    int p;
    longint unsigned rest;
    longint unsigned frac;
    p = 63;
    while (p > 0 && x[p] == 1'b0) p--;
    rest = x - (64'd1 << p);
    frac = (p >= 16) ? (rest >> (p - 16)) : (rest << (16 - p));
    if (p < FracBits) return 0;
    return (longint'(p - FracBits) << 16) + frac;
  endfunction

  function automatic logic [7:0] predict_index(input logic [31:0] pix);
    longint          offset;
    longint unsigned n;
    longint unsigned ceiling;
    longint unsigned q;
    longint unsigned r;
    longint unsigned x;
    longint unsigned lr;
    offset = longint'($signed(pix)) - longint'(cur_zero);
    n = cur_colors;
    ceiling = (n <= 1) ? 0 : (n > 256) ? 255 : n - 1;
    if (cur_log) begin
      r = (cur_range < 31'h20000) ? 64'h20000 : longint'(cur_range);
      x = (offset > 64'sh10000) ? longint'(offset) : 64'h10000;
      lr = approx_log2(r);
      if (lr == 0) lr = 1;
      q = (n * approx_log2(x)) / lr;
    end else begin
      r = (cur_range == 0) ? 1 : longint'(cur_range);
      q = (offset <= 0) ? 0 : (n * longint'(offset)) / r;
    end
    if (q > ceiling) q = ceiling;
    return q[7:0];
  endfunction

  // Results cannot be held off, so every strobe is checked on its own edge.
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && done_o) begin
      if (index_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: index %0d", color_index_o);
      end else begin
        want = index_queue.pop_front();
        if (color_index_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color_index: expected %0d, got %0d", want, color_index_o);
        end
      end
    end
  end

  // Random gap length: mostly none or short, occasionally long.
  function automatic int gap_length();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One request: drive the pixel and hold start until busy is seen low.
  task automatic send_pixel(input logic [31:0] pix, input bit gaps);
    int wait_cycles;
    start_i <= 1'b1;
    pixel_i <= pix;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    index_queue.push_back(predict_index(pix));
    if (gaps) begin
      wait_cycles = gap_length();
      if (wait_cycles > 0) begin
        start_i <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
    end
  endtask

  task automatic end_burst();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits for all outstanding results before a register may change.
  task automatic drain();
    start_i <= 1'b0;
    while (index_queue.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      RegNumColors: cur_colors = val[8:0];
      RegZeroLevel: cur_zero   = val;
      RegRange:     cur_range  = val[30:0];
      RegLogMode:   cur_log    = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [8:0] n, input logic [31:0] z, input logic [30:0] r,
                         input logic lg);
    write_reg(RegNumColors, {23'd0, n});
    write_reg(RegZeroLevel, z);
    write_reg(RegRange, {1'b0, r});
    write_reg(RegLogMode, {31'd0, lg});
    cfg_we_i <= 1'b0;
  endtask

  // Reset values, with extreme pixels sent as one burst with no gaps.
  task automatic test_reset_defaults();
    send_pixel(32'h8000_0000, 1'b0);
    send_pixel(32'h7FFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h0000_0001, 1'b0);
    send_pixel(32'h00FF_FFFF, 1'b0);
    send_pixel(32'h0100_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    end_burst();
    drain();
  endtask

  // Linear corner cases: zero range, few and many colours, wide offsets.
  task automatic test_linear_edges();
    set_all(9'd511, 32'h8000_0000, 31'd0, 1'b0);
    send_pixel(32'h8000_0000, 1'b1);
    send_pixel(32'h8000_0001, 1'b1);
    send_pixel(32'h7FFF_FFFF, 1'b1);
    drain();
    set_all(9'd1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send_pixel(32'h8000_0000, 1'b1);
    send_pixel(32'h7FFF_FFFF, 1'b1);
    drain();
    set_all(9'd0, 32'd0, 31'd1, 1'b0);
    send_pixel(32'h7FFF_FFFF, 1'b1);
    drain();
  endtask

  // Log corner cases: offsets below one, ranges below two, largest values.
  task automatic test_log_edges();
    set_all(9'd256, 32'd0, 31'd1, 1'b1);
    send_pixel(32'h0000_FFFF, 1'b1);
    send_pixel(32'h0001_0000, 1'b1);
    send_pixel(32'h0002_0000, 1'b1);
    send_pixel(32'h7FFF_FFFF, 1'b1);
    send_pixel(32'h8000_0000, 1'b1);
    drain();
    set_all(9'd2, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1);
    send_pixel(32'h7FFF_FFFF, 1'b1);
    send_pixel(32'h0000_0000, 1'b1);
    drain();
  endtask

  // Random pixels; most land inside the range so the index takes many values.
  task automatic random_phase(input int count);
    logic [31:0] pix;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) pix = cur_zero + (cur_log ? ($urandom() >> $urandom_range(0, 31))
                                              : $urandom_range(0, cur_range + 31'd64));
      else pix = $urandom();
      send_pixel(pix, 1'b1);
    end
    drain();
  endtask

  task automatic test_random_settings();
    logic [8:0]  n;
    logic [30:0] r;
    for (int s = 0; s < 8; s++) begin
      n = (s == 0) ? 9'd2 : (s == 1) ? 9'd256 : (s == 2) ? 9'd511 : 9'($urandom_range(2, 300));
      r = (s == 3) ? 31'h7FFF_FFFF : 31'($urandom() >> $urandom_range(1, 28));
      set_all(n, $urandom(), r, s[0]);
      random_phase(50);
    end
  endtask

  initial begin
    cur_colors = 9'd256;
    cur_zero   = 32'sd0;
    cur_range  = 31'd16777216;
    cur_log    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_linear_edges();
    test_log_edges();
    test_random_settings();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
